FILE: rtl/dpb_pkg.sv
// Shared widths, register indexes, stream payload layouts and pipeline sideband type
// for the depth pixel back-projection block. Depends on nothing.
package dpb_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH = 3'd4;

    localparam logic [CFG_DATA_W-1:0] MAX_DEPTH_RESET = 16'd10000;

    localparam int unsigned MM_PER_M = 1000;
    localparam int          FRAC_W   = 16;
    localparam int          SUBPIX_W = 4;

    localparam int COORD_W = 12;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int POINT_W = 32;
    localparam int PROD_W  = 2 * DEPTH_W;

    // Divider: numerator (diff*depth) << 16 plus half divisor, divisor 1000*focal.
    localparam int DIV_NUM_W  = PROD_W + FRAC_W + 1;
    localparam int DIV_DEN_W  = 26;
    localparam int DIV_Q_W    = POINT_W - 1;
    localparam int DIV_STAGES = DIV_Q_W + 1;

    // Depth scaling: (depth*65536 + 500) / 1000 == (depth*8192 + 62) / 125,
    // the division by 125 done as a multiply by ceil(2^36 / 125) and a shift.
    localparam int                   Z_PRE       = 3;
    localparam int                   Z_NUM_SHIFT = FRAC_W - Z_PRE;
    localparam int                   Z_NUM_W     = DEPTH_W + Z_NUM_SHIFT;
    localparam logic [Z_NUM_W-1:0]   Z_ROUND     = Z_NUM_W'((MM_PER_M / 2) >> Z_PRE);
    localparam int                   Z_RECIP_W   = 30;
    localparam logic [Z_RECIP_W-1:0] Z_RECIP     = 30'd549755814;
    localparam int                   Z_SHIFT     = 36;
    localparam int                   Z_PROD_W    = Z_NUM_W + Z_RECIP_W;

    localparam logic [POINT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [POINT_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
        logic [DEPTH_W-1:0] depth_mm;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
    } pixel_t;

    typedef struct packed {
        logic [COLOR_W-1:0]        blue_out;
        logic [COLOR_W-1:0]        green_out;
        logic [COLOR_W-1:0]        red_out;
        logic [POINT_W-1:0]        point_z;
        logic signed [POINT_W-1:0] point_y;
        logic signed [POINT_W-1:0] point_x;
    } point_t;

    localparam int IN_W  = $bits(pixel_t);
    localparam int OUT_W = $bits(point_t);

    typedef struct packed {
        logic               valid;
        logic               depth_ok;
        logic               neg_x;
        logic               neg_y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } side_t;

endpackage

FILE: rtl/dpb_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// saturation flag for quotients of 2^31 and above. Depends on dpb_pkg.
module dpb_div_pipe (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [dpb_pkg::DIV_NUM_W-1:0]  num,
    input  logic [dpb_pkg::DIV_DEN_W-1:0]  den,
    output logic [dpb_pkg::DIV_Q_W-1:0]    quo,
    output logic                           sat
);

    localparam int NW = dpb_pkg::DIV_NUM_W;
    localparam int DW = dpb_pkg::DIV_DEN_W;
    localparam int QW = dpb_pkg::DIV_Q_W;
    localparam int CW = DW + QW;

    logic [NW-1:0] rem_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic          sat_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            sat_reg[0] <= (CW'(num) >= (CW'(den) << QW));
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        localparam int B = QW - k;
        logic [CW-1:0] trial;
        logic [CW-1:0] diff;
        logic          ge;
        logic [QW-1:0] quo_next;

        always_comb begin
            trial       = CW'(den) << B;
            ge          = (CW'(rem_reg[k-1]) >= trial);
            diff        = CW'(rem_reg[k-1]) - trial;
            quo_next    = quo_reg[k-1];
            quo_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[NW-1:0] : rem_reg[k-1];
                quo_reg[k] <= quo_next;
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign sat = sat_reg[QW];

endmodule

FILE: rtl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection block: configuration registers,
// pixel pipeline, two divider lanes, depth scaling and output skid stage.
// Depends on dpb_pkg, dpb_div_pipe.
//
// Usage:
//   Pixels enter on the s_ stream (column, row, depth in mm, BGR colour), one
//   transaction per cycle. Each pixel yields one point on the m_ stream: x, y
//   in signed Q15.16 metres (saturated), z in unsigned Q16.16 metres, colour
//   reordered RGB. Depths of zero or at/above max_depth_mm give a zero point.
//   While focal_x or focal_y is zero, pixels are taken and dropped.
//   Configuration goes through cfg_wr_en/cfg_addr/cfg_wr_data, one register
//   per write. The user must write only while no pixel is in flight; the
//   block does not enforce it. Throughput: one pixel per cycle unless
//   stalled. Each pixel passes three front stages, the 32 register stages
//   of the dividers, a format register and the output register to m_tdata.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the
//   registers: focal lengths and centers to zero, max_depth_mm to 10000.
//   When the receiver stalls, the result in flight parks in a skid register;
//   s_tready then drops and the whole pipeline holds until it drains.
module depth_pixel_backprojection (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dpb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // column[11:0], row[23:12], depth_mm[39:24], blue_in[47:40],
    // green_in[55:48], red_in[63:56]
    input  logic [dpb_pkg::IN_W-1:0]         s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], red_out[103:96],
    // green_out[111:104], blue_out[119:112]
    output logic [dpb_pkg::OUT_W-1:0]        m_tdata
);

    localparam int DEPTH_W = dpb_pkg::DEPTH_W;
    localparam int PROD_W  = dpb_pkg::PROD_W;
    localparam int NUM_W   = dpb_pkg::DIV_NUM_W;
    localparam int DEN_W   = dpb_pkg::DIV_DEN_W;
    localparam int Q_W     = dpb_pkg::DIV_Q_W;
    localparam int PT_W    = dpb_pkg::POINT_W;
    localparam int NSTG    = dpb_pkg::DIV_STAGES;
    localparam int DATA_W  = dpb_pkg::CFG_DATA_W;
    localparam int ZN_W    = dpb_pkg::Z_NUM_W;
    localparam int ZP_W    = dpb_pkg::Z_PROD_W;

    logic [DATA_W-1:0] focal_x_reg;
    logic [DATA_W-1:0] focal_y_reg;
    logic [DATA_W-1:0] center_x_reg;
    logic [DATA_W-1:0] center_y_reg;
    logic [DATA_W-1:0] max_depth_reg;
    logic [DEN_W-1:0]  den_x_reg;
    logic [DEN_W-1:0]  den_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg   <= '0;
            focal_y_reg   <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            max_depth_reg <= dpb_pkg::MAX_DEPTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dpb_pkg::REG_FOCAL_X:   focal_x_reg   <= cfg_wr_data;
                dpb_pkg::REG_FOCAL_Y:   focal_y_reg   <= cfg_wr_data;
                dpb_pkg::REG_CENTER_X:  center_x_reg  <= cfg_wr_data;
                dpb_pkg::REG_CENTER_Y:  center_y_reg  <= cfg_wr_data;
                dpb_pkg::REG_MAX_DEPTH: max_depth_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        den_x_reg <= DEN_W'(focal_x_reg * dpb_pkg::MM_PER_M);
        den_y_reg <= DEN_W'(focal_y_reg * dpb_pkg::MM_PER_M);
    end

    // Pipeline control
    logic skid_valid_reg;
    logic en;
    logic s_accept;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign s_accept = s_tvalid && s_tready;

    // Stage 1: offsets from the principal point, depth range check
    dpb_pkg::pixel_t   pix;
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    dpb_pkg::side_t    sb1_next;
    logic [DATA_W-1:0] diff_x1_next;
    logic [DATA_W-1:0] diff_y1_next;

    always_comb begin
        pix                = dpb_pkg::pixel_t'(s_tdata);
        pos_x              = {pix.column, dpb_pkg::SUBPIX_W'(0)};
        pos_y              = {pix.row, dpb_pkg::SUBPIX_W'(0)};
        sb1_next.valid     = s_accept && (focal_x_reg != '0) && (focal_y_reg != '0);
        sb1_next.depth_ok  = (pix.depth_mm != '0) && (pix.depth_mm < max_depth_reg);
        sb1_next.neg_x     = pos_x < center_x_reg;
        sb1_next.neg_y     = pos_y < center_y_reg;
        sb1_next.red       = pix.red_in;
        sb1_next.green     = pix.green_in;
        sb1_next.blue      = pix.blue_in;
        diff_x1_next       = sb1_next.neg_x ? (center_x_reg - pos_x) : (pos_x - center_x_reg);
        diff_y1_next       = sb1_next.neg_y ? (center_y_reg - pos_y) : (pos_y - center_y_reg);
    end

    dpb_pkg::side_t     sb1_reg;
    logic [DATA_W-1:0]  diff_x1_reg;
    logic [DATA_W-1:0]  diff_y1_reg;
    logic [DEPTH_W-1:0] depth1_reg;

    dpb_pkg::side_t     sb2_reg;
    logic [PROD_W-1:0]  prod_x2_reg;
    logic [PROD_W-1:0]  prod_y2_reg;
    logic [ZN_W-1:0]    zn2_reg;

    dpb_pkg::side_t     sb3_reg;
    logic [NUM_W-1:0]   num_x3_reg;
    logic [NUM_W-1:0]   num_y3_reg;
    logic [PT_W-1:0]    z3_reg;

    dpb_pkg::side_t     sb_dly_reg [0:NSTG-1];
    logic [PT_W-1:0]    z_dly_reg [0:NSTG-1];
    logic [ZP_W-1:0]    z_prod;

    assign z_prod = ZP_W'(zn2_reg) * ZP_W'(dpb_pkg::Z_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb1_reg.valid <= 1'b0;
            sb2_reg.valid <= 1'b0;
            sb3_reg.valid <= 1'b0;
            for (int i = 0; i < NSTG; i++) begin
                sb_dly_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            sb1_reg       <= sb1_next;
            sb2_reg       <= sb1_reg;
            sb3_reg       <= sb2_reg;
            sb_dly_reg[0] <= sb3_reg;
            for (int i = 1; i < NSTG; i++) begin
                sb_dly_reg[i] <= sb_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_x1_reg <= diff_x1_next;
            diff_y1_reg <= diff_y1_next;
            depth1_reg  <= pix.depth_mm;
            prod_x2_reg <= PROD_W'(diff_x1_reg * depth1_reg);
            prod_y2_reg <= PROD_W'(diff_y1_reg * depth1_reg);
            zn2_reg     <= {depth1_reg, dpb_pkg::Z_NUM_SHIFT'(0)} + dpb_pkg::Z_ROUND;
            num_x3_reg  <= NUM_W'({prod_x2_reg, dpb_pkg::FRAC_W'(0)}) + NUM_W'(den_x_reg >> 1);
            num_y3_reg  <= NUM_W'({prod_y2_reg, dpb_pkg::FRAC_W'(0)}) + NUM_W'(den_y_reg >> 1);
            z3_reg      <= PT_W'(z_prod >> dpb_pkg::Z_SHIFT);
            z_dly_reg[0] <= z3_reg;
            for (int i = 1; i < NSTG; i++) begin
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
        end
    end

    // Divider lanes
    logic [Q_W-1:0] quo_x;
    logic [Q_W-1:0] quo_y;
    logic           sat_x;
    logic           sat_y;

    dpb_div_pipe u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (num_x3_reg),
        .den  (den_x_reg),
        .quo  (quo_x),
        .sat  (sat_x)
    );

    dpb_div_pipe u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (num_y3_reg),
        .den  (den_y_reg),
        .quo  (quo_y),
        .sat  (sat_y)
    );

    // Format stage: sign, saturation, invalid-depth zeroing
    dpb_pkg::side_t sb_last;
    logic [PT_W-1:0] mag_x;
    logic [PT_W-1:0] mag_y;
    dpb_pkg::point_t fmt_next;

    always_comb begin
        sb_last            = sb_dly_reg[NSTG-1];
        mag_x              = {1'b0, quo_x};
        mag_y              = {1'b0, quo_y};
        fmt_next.red_out   = sb_last.red;
        fmt_next.green_out = sb_last.green;
        fmt_next.blue_out  = sb_last.blue;
        if (!sb_last.depth_ok) begin
            fmt_next.point_x = '0;
            fmt_next.point_y = '0;
            fmt_next.point_z = '0;
        end else begin
            if (sat_x) begin
                fmt_next.point_x = sb_last.neg_x ? dpb_pkg::SAT_NEG : dpb_pkg::SAT_POS;
            end else begin
                fmt_next.point_x = sb_last.neg_x ? (~mag_x + PT_W'(1)) : mag_x;
            end
            if (sat_y) begin
                fmt_next.point_y = sb_last.neg_y ? dpb_pkg::SAT_NEG : dpb_pkg::SAT_POS;
            end else begin
                fmt_next.point_y = sb_last.neg_y ? (~mag_y + PT_W'(1)) : mag_y;
            end
            fmt_next.point_z = z_dly_reg[NSTG-1];
        end
    end

    logic            fmt_valid_reg;
    dpb_pkg::point_t fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_valid_reg <= 1'b0;
        end else if (en) begin
            fmt_valid_reg <= sb_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fmt_reg <= fmt_next;
        end
    end

    // Output register and skid
    logic            m_valid_reg;
    dpb_pkg::point_t m_data_reg;
    dpb_pkg::point_t skid_data_reg;
    logic            new_valid;

    assign new_valid = fmt_valid_reg && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= new_valid;
            end
        end else if (new_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : fmt_reg;
        end else if (new_valid) begin
            skid_data_reg <= fmt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Assertions
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds data while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready && fmt_valid_reg))
        else $error("skid filled without a stalled output");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while the receiver stalled");

endmodule
